[rtl/dzs_pkg.sv]
// ----------------------------------------------------------------------------
// dzs_pkg
// shared types and constants for the diagonal zigzag scan generator
// ----------------------------------------------------------------------------
package dzs_pkg;

  localparam int COORD_W = 10;
  localparam int DIAG_W  = COORD_W + 1;
  localparam int CFG_IDX_W = 1;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [DIAG_W-1:0]    diag_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LAST_COLUMN = 1'd0;
  localparam cfg_idx_t CFG_LAST_ROW    = 1'd1;

  localparam coord_t LAST_COLUMN_RST = 10'd79;
  localparam coord_t LAST_ROW_RST    = 10'd24;

  typedef struct packed {
    coord_t column;
    coord_t row;
    logic   moving_up;
    diag_t  diag;
    logic   finished;
  } scan_state_t;

endpackage

[rtl/diagonal_zigzag_scan_generator.sv]
// ----------------------------------------------------------------------------
// diagonal_zigzag_scan_generator
// zigzag diagonal scan of a rectangle, one coordinate per transfer
// ----------------------------------------------------------------------------
// usage:
//   each input transfer (in_restart) produces exactly one result transfer.
//   in_restart = 1 restarts the scan at the top-right corner and emits that
//   corner; in_restart = 0 emits the next position of the scan.
//   the result carries column, row, end-of-diagonal and end-of-scan flags;
//   once the scan is over, results come with out_valid_res = 0 and zero fields.
//   cfg_we writes last_column (index 0) or last_row (index 1);
//   write only while no transfer is in flight.
// timing:
//   the result register loads at the input transfer, so the result is out in the next cycle.
//   throughput is one item per cycle while in_stall is low; the next-position
//   logic (one add and compare chain on the diagonal start point) sits between
//   the state registers and the result register.
//   in_stall is high only while a result is held and out_stall is high.
// reset:
//   synchronous, active low; registers return to 79 and 24, the scan to the
//   top-right corner, and the result register empties.
// ----------------------------------------------------------------------------
module diagonal_zigzag_scan_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  dzs_pkg::cfg_idx_t cfg_index,
  input  dzs_pkg::coord_t   cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output dzs_pkg::coord_t   out_column,
  output dzs_pkg::coord_t   out_row,
  output logic              out_diagonal_end,
  output logic              out_scan_end,
  output logic              out_valid_res
);

  import dzs_pkg::*;

  localparam int SW = COORD_W + 3;

  coord_t      last_column_r;
  coord_t      last_row_r;
  scan_state_t state_r;
  scan_state_t state_nxt;
  scan_state_t eff;
  logic        out_valid_r;
  logic        out_valid_nxt;
  coord_t      out_column_r;
  coord_t      out_row_r;
  logic        out_diagonal_end_r;
  logic        out_scan_end_r;
  logic        out_valid_res_r;

  logic            in_xfer;
  logic            diag_end;
  logic            scan_end;
  diag_t           diag_sum;
  diag_t           diag_inc;
  logic signed [SW-1:0] w_s;
  logic signed [SW-1:0] d_s;
  logic signed [SW-1:0] sum_s;
  logic signed [SW-1:0] x_s;
  logic signed [SW-1:0] y_s;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // scan state as seen by this item, after a possible restart
  always_comb begin
    if (in_restart) begin
      eff.column    = last_column_r;
      eff.row       = '0;
      eff.moving_up = 1'b1;
      eff.diag      = '0;
      eff.finished  = 1'b0;
    end else begin
      eff = state_r;
    end
  end

  always_comb begin
    if (eff.moving_up) begin
      diag_end = (eff.column == '0) || (eff.row == '0);
    end else begin
      diag_end = (eff.column >= last_column_r) || (eff.row >= last_row_r);
    end
    diag_sum = {1'b0, last_column_r} + {1'b0, last_row_r};
    scan_end = diag_end && (eff.diag >= diag_sum);
    diag_inc = eff.diag + 1'b1;
  end

  // start point of the next diagonal
  always_comb begin
    w_s   = $signed({3'b000, last_column_r});
    d_s   = w_s - $signed({2'b00, diag_inc});
    sum_s = d_s + $signed({3'b000, last_row_r});
    if (!diag_inc[0]) begin
      x_s = (sum_s > w_s) ? w_s : sum_s;
    end else begin
      x_s = d_s;
    end
    if (x_s < 0) begin
      x_s = '0;
    end
    y_s = x_s - d_s;
    if (y_s < 0) begin
      y_s = '0;
    end
  end

  always_comb begin
    state_nxt = eff;
    if (eff.finished) begin
      state_nxt = eff;
    end else if (scan_end) begin
      state_nxt.finished = 1'b1;
    end else if (diag_end) begin
      state_nxt.diag      = diag_inc;
      state_nxt.column    = x_s[COORD_W-1:0];
      state_nxt.row       = y_s[COORD_W-1:0];
      state_nxt.moving_up = ~diag_inc[0];
    end else if (eff.moving_up) begin
      state_nxt.column = eff.column - 1'b1;
      state_nxt.row    = eff.row - 1'b1;
    end else begin
      state_nxt.column = eff.column + 1'b1;
      state_nxt.row    = eff.row + 1'b1;
    end
  end

  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_column_r      <= LAST_COLUMN_RST;
      last_row_r         <= LAST_ROW_RST;
      state_r.column     <= LAST_COLUMN_RST;
      state_r.row        <= '0;
      state_r.moving_up  <= 1'b1;
      state_r.diag       <= '0;
      state_r.finished   <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LAST_COLUMN: last_column_r <= cfg_wdata;
          CFG_LAST_ROW:    last_row_r    <= cfg_wdata;
          default:         last_row_r    <= last_row_r;
        endcase
      end
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_column_r       <= eff.finished ? '0 : eff.column;
      out_row_r          <= eff.finished ? '0 : eff.row;
      out_diagonal_end_r <= !eff.finished && diag_end;
      out_scan_end_r     <= !eff.finished && scan_end;
      out_valid_res_r    <= !eff.finished;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column       = out_column_r;
  assign out_row          = out_row_r;
  assign out_diagonal_end = out_diagonal_end_r;
  assign out_scan_end     = out_scan_end_r;
  assign out_valid_res    = out_valid_res_r;

`ifndef SYNTH
  a_dir_parity: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.moving_up == ~state_r.diag[0])
    else $error("direction does not match diagonal parity");

  a_scan_end_on_diag_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scan_end_r |-> out_diagonal_end_r && out_valid_res_r)
    else $error("scan end without diagonal end");

  a_finished_gives_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && state_r.finished && !in_restart |=> out_valid_r && !out_valid_res_r)
    else $error("position emitted after end of scan");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_valid_res_r |-> out_column_r == '0 && out_row_r == '0)
    else $error("empty result carries a position");
`endif

endmodule

[sim/tb_diagonal_zigzag_scan_generator.sv]
// ----------------------------------------------------------------------------
// tb_diagonal_zigzag_scan_generator
// self-checking bench for the diagonal zigzag scan generator
// ----------------------------------------------------------------------------
// a queue of restart bits feeds a clocked driver. Each accepted input goes
// through a scan predictor that keeps its own copy of the position, the
// direction, the diagonal count and the rectangle size. The predicted
// position is queued, and a clocked monitor compares every result transfer
// field by field with the oldest prediction.
// stimulus starts with directed corner cases: a single point, a single row,
// a single column, the largest rectangle and a size change in mid-scan.
// Random phases follow. Most of them are small rectangles scanned past their
// end, and a few are large ones. Some phases keep the old scan going after a
// size change, and some scatter restarts at random. Both sides idle at
// random, with some phases that run without gaps.
// ----------------------------------------------------------------------------
module tb_diagonal_zigzag_scan_generator;
  import dzs_pkg::*;

  typedef struct packed {
    coord_t column;
    coord_t row;
    logic   diagonal_end;
    logic   scan_end;
    logic   valid_res;
  } scan_pos_t;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 550;
  localparam int PHASE_CAP    = 60;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_LAST_COLUMN;
  coord_t   cfg_wdata = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     in_restart = 1'b0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  coord_t   out_column;
  coord_t   out_row;
  logic     out_diagonal_end;
  logic     out_scan_end;
  logic     out_valid_res;

  // rectangle size and scan position as the predictor sees them
  coord_t model_last_column;
  coord_t model_last_row;
  coord_t pos_column;
  coord_t pos_row;
  logic   pos_up;
  diag_t  pos_diag;
  logic   pos_done;

  bit        restart_q[$];
  scan_pos_t expected_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        steady = 1'b0;

  diagonal_zigzag_scan_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_diagonal_end (out_diagonal_end),
    .out_scan_end     (out_scan_end),
    .out_valid_res    (out_valid_res)
  );

  always #1 clk = ~clk;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic void start_scan();
    pos_column = model_last_column;
    pos_row    = '0;
    pos_up     = 1'b1;
    pos_diag   = '0;
    pos_done   = 1'b0;
  endfunction

  // first position of diagonal pos_diag under the current size
  function automatic void enter_diagonal();
    int w;
    int h;
    int d;
    int x;
    int y;
    w = int'(model_last_column);
    h = int'(model_last_row);
    d = w - int'(pos_diag);
    if (!pos_diag[0]) begin
      x = d + h;
      if (x > w) x = w;
    end else begin
      x = (d > 0) ? d : 0;
    end
    if (x < 0) x = 0;
    y = x - d;
    if (y < 0) y = 0;
    pos_column = x[COORD_W-1:0];
    pos_row    = y[COORD_W-1:0];
    pos_up     = !pos_diag[0];
  endfunction

  function automatic void advance_scan(logic restart);
    scan_pos_t res;
    logic      at_end;
    logic      at_last;
    int        span;
    res  = '0;
    span = int'(model_last_column) + int'(model_last_row);
    if (restart) start_scan();
    if (!pos_done) begin
      if (pos_up) at_end = (pos_column == '0) || (pos_row == '0);
      else at_end = (pos_column >= model_last_column) || (pos_row >= model_last_row);
      at_last = at_end && (int'(pos_diag) >= span);
      res.column       = pos_column;
      res.row          = pos_row;
      res.diagonal_end = at_end;
      res.scan_end     = at_last;
      res.valid_res    = 1'b1;
      if (at_last) begin
        pos_done = 1'b1;
      end else if (at_end) begin
        pos_diag = pos_diag + 1'b1;
        enter_diagonal();
      end else if (pos_up) begin
        pos_column = pos_column - 1'b1;
        pos_row    = pos_row - 1'b1;
      end else begin
        pos_column = pos_column + 1'b1;
        pos_row    = pos_row + 1'b1;
      end
    end
    expected_q.push_back(res);
  endfunction

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_flag(string name, logic got, logic want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_position();
    scan_pos_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result column %0d row %0d", out_column, out_row));
    end else begin
      want = expected_q.pop_front();
      check_field("column", out_column, want.column);
      check_field("row", out_row, want.row);
      check_flag("diagonal_end", out_diagonal_end, want.diagonal_end);
      check_flag("scan_end", out_scan_end, want.scan_end);
      check_flag("valid_res", out_valid_res, want.valid_res);
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic next_valid;
    logic next_restart;
    next_valid   = in_valid;
    next_restart = in_restart;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_scan(in_restart);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (restart_q.size() > 0) begin
          next_restart = restart_q.pop_front();
          next_valid   = 1'b1;
          send_gap     = steady ? 0 : idle_length();
        end
      end
    end
    in_valid   <= next_valid;
    in_restart <= next_restart;
  end

  // monitor
  always @(posedge clk) begin : watch
    logic next_stall;
    int   n;
    next_stall = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) check_position();
      if (!steady) begin
        if (stall_left > 0) begin
          next_stall = 1'b1;
          stall_left--;
        end else begin
          n = idle_length();
          if (n > 0) begin
            next_stall = 1'b1;
            stall_left = n - 1;
          end
        end
      end
    end
    out_stall <= next_stall;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_diagonal_zigzag_scan_generator: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while (restart_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, coord_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_LAST_COLUMN) model_last_column = value;
    else model_last_row = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(coord_t last_column, coord_t last_row);
    drain();
    write_reg(CFG_LAST_COLUMN, last_column);
    write_reg(CFG_LAST_ROW, last_row);
  endtask

  task automatic add_items(int n, bit first_restart);
    restart_q.push_back(first_restart);
    for (int i = 1; i < n; i++) restart_q.push_back(1'b0);
  endtask

  initial begin : stimulus
    int     pick;
    int     which;
    int     n;
    int     sent;
    int     positions;
    bit     noisy;
    coord_t col;
    coord_t row;
    model_last_column = LAST_COLUMN_RST;
    model_last_row    = LAST_ROW_RST;
    start_scan();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset size: corner right out of reset, then a restart
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    // single point: scan ends at once, then idle results
    set_size(10'd0, 10'd0);
    add_items(3, 1'b1);
    set_size(10'd1023, 10'd0);
    add_items(3, 1'b1);
    set_size(10'd0, 10'd1023);
    add_items(3, 1'b1);
    set_size(10'd1023, 10'd1023);
    add_items(3, 1'b1);
    set_size(10'd3, 10'd2);
    add_items(5, 1'b1);
    // shrink mid-scan
    drain();
    write_reg(CFG_LAST_COLUMN, 10'd1);
    add_items(5, 1'b0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        col = coord_t'($urandom_range(0, 7));
        row = coord_t'($urandom_range(0, 7));
      end else if (pick < 15) begin
        col = coord_t'($urandom_range(0, 40));
        row = coord_t'($urandom_range(0, 3));
      end else if (pick < 18) begin
        col = coord_t'($urandom_range(0, 3));
        row = coord_t'($urandom_range(0, 40));
      end else begin
        col = ($urandom_range(0, 1) == 0) ? 10'd1023 : coord_t'($urandom_range(0, 1023));
        row = ($urandom_range(0, 1) == 0) ? 10'd0 : coord_t'($urandom_range(0, 1023));
      end
      which = $urandom_range(0, 6);
      if (which < 5) write_reg(CFG_LAST_COLUMN, col);
      if (which < 4 || which == 5) write_reg(CFG_LAST_ROW, row);
      positions = (int'(model_last_column) + 1) * (int'(model_last_row) + 1);
      n = (positions > PHASE_CAP) ? PHASE_CAP : positions;
      n += $urandom_range(0, 3);
      noisy = ($urandom_range(0, 7) == 0);
      restart_q.push_back($urandom_range(0, 4) != 0);
      for (int i = 1; i < n; i++) restart_q.push_back(noisy && ($urandom_range(0, 5) == 0));
      sent += n;
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_diagonal_zigzag_scan_generator: PASS");
    end else begin
      $display("tb_diagonal_zigzag_scan_generator: FAIL");
    end
    $finish;
  end

endmodule
